/* rtl/spr_pkg.sv */
// Shared types, opcodes and constants of the saturating play clock and race stopwatch.
package spr_pkg;

   localparam int FPS_W        = 6;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 6;

   localparam logic [FPS_W-1:0] FPS_RESET = 6'd60;
   localparam logic [5:0] SEC_PER_MIN     = 6'd60;
   localparam logic [5:0] MIN_PER_HOUR    = 6'd60;
   localparam logic [5:0] LAST_SEC        = 6'd59;
   localparam logic [5:0] LAST_MIN        = 6'd59;
   localparam logic [7:0] LAST_HOUR       = 8'd255;
   localparam logic [6:0] RACE_LAST_MIN   = 7'd99;
   localparam logic [3:0] LAST_TENTH      = 4'd9;

   // Operation codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FPS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAL = 1'd1;

   typedef struct packed {
      logic [1:0] op;
      logic       clock_owned;
      logic       frozen;
      logic       controls_locked;
      logic       is_paused;
      logic       window_covers;
      logic [7:0] load_hour;
      logic [5:0] load_minute;
      logic [5:0] load_second;
      logic [5:0] load_frame;
   } req_type;

   typedef struct packed {
      logic [7:0] play_hour;
      logic [5:0] play_minute;
      logic [5:0] play_second;
      logic [5:0] play_frame;
      logic [6:0] race_minute;
      logic [5:0] race_second;
      logic [3:0] race_decisecond;
      logic       redraw_minutes;
      logic       redraw_seconds;
      logic       redraw_tenths;
      logic       show_counter;
   } rsp_type;

   typedef struct packed {
      logic [7:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [5:0] frame;
   } play_time_type;

   typedef struct packed {
      logic [6:0] minute;
      logic [5:0] second;
      logic [5:0] frame;
      logic [3:0] tenths;
   } race_time_type;

   typedef struct packed {
      logic minutes;
      logic seconds;
      logic tenths;
   } redraw_type;

endpackage

/* rtl/spr_play_tick.sv */
// One frame step of the play-time clock, saturating at 255:59:59 and the last frame.
module spr_play_tick (
   input  spr_pkg::play_time_type         play_cur,
   input  logic [spr_pkg::FPS_W-1:0]      fps_eff,
   output spr_pkg::play_time_type         play_next
);
   import spr_pkg::*;

   logic [FPS_W:0] frame_inc;
   logic [6:0]     second_inc;
   logic [6:0]     minute_inc;
   logic [8:0]     hour_inc;

   assign frame_inc  = {1'b0, play_cur.frame} + 7'd1;
   assign second_inc = {1'b0, play_cur.second} + 7'd1;
   assign minute_inc = {1'b0, play_cur.minute} + 7'd1;
   assign hour_inc   = {1'b0, play_cur.hour} + 9'd1;

   always_comb begin
      play_next = play_cur;
      if (frame_inc < {1'b0, fps_eff}) begin
         play_next.frame = frame_inc[FPS_W-1:0];
      end else if (second_inc < {1'b0, SEC_PER_MIN}) begin
         play_next.frame  = '0;
         play_next.second = second_inc[5:0];
      end else if (minute_inc < {1'b0, MIN_PER_HOUR}) begin
         play_next.frame  = '0;
         play_next.second = '0;
         play_next.minute = minute_inc[5:0];
      end else if (hour_inc > {1'b0, LAST_HOUR}) begin
         // hold at the top of the range
         play_next.hour   = LAST_HOUR;
         play_next.minute = LAST_MIN;
         play_next.second = LAST_SEC;
         play_next.frame  = fps_eff - 6'd1;
      end else begin
         play_next.frame  = '0;
         play_next.second = '0;
         play_next.minute = '0;
         play_next.hour   = hour_inc[7:0];
      end
   end

endmodule

/* rtl/spr_race_tick.sv */
// One frame step of the race stopwatch with decisecond digit and redraw pulses.
module spr_race_tick (
   input  spr_pkg::race_time_type         race_cur,
   input  logic [spr_pkg::FPS_W-1:0]      fps_eff,
   input  logic                           pal_rule,
   output spr_pkg::race_time_type         race_next,
   output spr_pkg::redraw_type            redraw
);
   import spr_pkg::*;

   logic [FPS_W:0] frame_inc;
   logic [6:0]     second_inc;
   logic [7:0]     minute_inc;
   logic [9:0]     prod_pal;
   logic [11:0]    prod_ntsc;
   logic [3:0]     quot;
   logic [3:0]     tenths;

   assign frame_inc  = {1'b0, race_cur.frame} + 7'd1;
   assign second_inc = {1'b0, race_cur.second} + 7'd1;
   assign minute_inc = {1'b0, race_cur.minute} + 8'd1;

   always_comb begin
      race_next = race_cur;
      redraw    = '0;
      if (frame_inc < {1'b0, fps_eff}) begin
         race_next.frame = frame_inc[FPS_W-1:0];
      end else if (second_inc < {1'b0, SEC_PER_MIN}) begin
         race_next.frame  = '0;
         race_next.second = second_inc[5:0];
         redraw.seconds   = 1'b1;
      end else if (minute_inc > {1'b0, RACE_LAST_MIN}) begin
         // hold at 99:59, no minute or second pulse
         race_next.minute = RACE_LAST_MIN;
         race_next.second = LAST_SEC;
         race_next.frame  = fps_eff - 6'd1;
      end else begin
         race_next.minute = minute_inc[6:0];
         race_next.second = '0;
         race_next.frame  = '0;
         redraw.minutes   = 1'b1;
         redraw.seconds   = 1'b1;
      end

      // frame/5 as (x*13)>>6 and frame/6 as (x*43)>>8, exact for six-bit x
      prod_pal  = 10'(race_next.frame) * 10'd13;
      prod_ntsc = 12'(race_next.frame) * 12'd43;
      quot      = pal_rule ? prod_pal[9:6] : prod_ntsc[11:8];
      tenths    = (quot > LAST_TENTH) ? LAST_TENTH : quot;

      race_next.tenths = tenths;
      redraw.tenths    = (tenths != race_cur.tenths);
   end

endmodule

/* rtl/saturating_play_and_race_clock_top.sv */
// Top level: play-time clock and race stopwatch with request/response registers.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  req     | in        | req_valid / req_stall   | req_data  (spr_pkg::req_type)
//  rsp     | out       | rsp_valid / rsp_stall   | rsp_data  (spr_pkg::rsp_type)
//  csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// A beat loads the request register at its accepting edge; once the response register
// is free or taken, the tick logic moves it into the response register and rsp_valid rises.
// One beat per cycle is sustained while rsp_stall is low, and state advances in order.
// reset is synchronous, active high: clear both clocks, the shown digit and the valid
// flags; set 60 frames per second and the NTSC rule. req_stall rises only when both
// registers are full and rsp_stall holds; csr_ready is always high, write when idle.
module saturating_play_and_race_clock_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  spr_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output spr_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [spr_pkg::CSR_DATA_W-1:0]      csr_data
);
   import spr_pkg::*;

   // configuration registers
   logic [FPS_W-1:0] fps_ff, fps_in;
   logic             pal_ff, pal_in;

   // request register
   logic             in_valid_ff, in_valid_in;
   req_type          in_item_ff;

   // response register
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_item_ff, out_item_in;

   // clock state
   play_time_type    play_ff, play_in;
   race_time_type    race_ff, race_in;

   logic             req_take;
   logic             advance;
   logic             race_run;
   logic [FPS_W-1:0] fps_eff;
   play_time_type    play_tick;
   race_time_type    race_tick;
   redraw_type       race_redraw;
   redraw_type       redraw;

   assign csr_ready = 1'b1;

   // drain the request register when the response register is free or taken
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   // a frame rate of zero acts as one
   assign fps_eff = (fps_ff == '0) ? 6'd1 : fps_ff;

   assign race_run = in_item_ff.clock_owned && !in_item_ff.frozen
                     && !in_item_ff.controls_locked && !in_item_ff.is_paused;

   spr_play_tick u_play_tick (
      .play_cur  (play_ff),
      .fps_eff   (fps_eff),
      .play_next (play_tick)
   );

   spr_race_tick u_race_tick (
      .race_cur  (race_ff),
      .fps_eff   (fps_eff),
      .pal_rule  (pal_ff),
      .race_next (race_tick),
      .redraw    (race_redraw)
   );

   // configuration writes
   always_comb begin
      fps_in = fps_ff;
      pal_in = pal_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FPS: fps_in = csr_data[FPS_W-1:0];
            CSR_PAL: pal_in = csr_data[0];
            default: ;
         endcase
      end
   end

   // next clock state and the result for the beat in the request register
   always_comb begin
      play_in = play_ff;
      race_in = race_ff;
      redraw  = '0;
      if (advance) begin
         unique case (in_item_ff.op)
            OP_TICK: begin
               play_in = play_tick;
               if (race_run) begin
                  race_in = race_tick;
                  redraw  = race_redraw;
               end
            end
            OP_CLEAR: begin
               play_in = '0;
               // keep the shown digit, zero the stopwatch time
               race_in.minute = '0;
               race_in.second = '0;
               race_in.frame  = '0;
            end
            OP_LOAD: begin
               play_in.hour   = in_item_ff.load_hour;
               play_in.minute = in_item_ff.load_minute;
               play_in.second = in_item_ff.load_second;
               play_in.frame  = in_item_ff.load_frame;
               race_in.minute = '0;
               race_in.second = '0;
               race_in.frame  = '0;
            end
            default: ;  // unused code: hold state
         endcase
      end

      out_item_in.play_hour       = play_in.hour;
      out_item_in.play_minute     = play_in.minute;
      out_item_in.play_second     = play_in.second;
      out_item_in.play_frame      = play_in.frame;
      out_item_in.race_minute     = race_in.minute;
      out_item_in.race_second     = race_in.second;
      out_item_in.race_decisecond = race_in.tenths;
      out_item_in.redraw_minutes  = redraw.minutes;
      out_item_in.redraw_seconds  = redraw.seconds;
      out_item_in.redraw_tenths   = redraw.tenths;
      out_item_in.show_counter    = in_item_ff.clock_owned && !in_item_ff.window_covers;
   end

   // valid flags: request fills on take and drops on drain; response fills on drain, drops when taken
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_ff       <= FPS_RESET;
         pal_ff       <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         play_ff      <= '0;
         race_ff      <= '0;
      end else begin
         fps_ff       <= fps_in;
         pal_ff       <= pal_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         play_ff      <= play_in;
         race_ff      <= race_in;
      end
   end

   // payload registers: request captures on take, response on drain; both hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   // stopwatch minutes never pass the saturation point
   assert property (@(posedge clock) disable iff (reset)
      race_ff.minute <= RACE_LAST_MIN)
      else $error("race minutes above saturation");

   // shown decisecond digit stays a single decimal digit
   assert property (@(posedge clock) disable iff (reset)
      race_ff.tenths <= LAST_TENTH)
      else $error("shown decisecond digit above nine");

   // a minute rollover always comes with a seconds redraw
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.redraw_minutes |-> rsp_data.redraw_seconds)
      else $error("minute redraw without seconds redraw");

   // back-pressure only when the request register is occupied
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("request stalled with a free register");

endmodule
